// ===== rtl/gcst_pkg.sv =====
// gcst_pkg: shared types, constants and op codes of the color gradient stop table
// no dependencies; imported by gcst_interp and color_gradient_stop_table_top
`timescale 1ns / 1ps

package gcst_pkg;

  localparam int unsigned MaxStopsDef = 16;

  localparam logic [15:0] OnePos  = 16'h8000;
  localparam logic [15:0] HalfPos = 16'h4000;

  localparam logic [31:0] TopColorRst    = 32'hFFFF_FFFF;
  localparam logic [31:0] BottomColorRst = 32'h0000_0000;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_ADD_MIRROR = 3'd1,
    OP_MIRROR     = 3'd2,
    OP_LOOKUP     = 3'd3,
    OP_RESTART    = 3'd4
  } op_e;

  // one table entry, color packed red in the high byte
  typedef struct packed {
    logic [15:0] pos;
    logic [31:0] col;
  } stop_t;

  localparam int unsigned StopW = $bits(stop_t);

  typedef struct packed {
    logic        start;
    logic [31:0] lo_col;
    logic [31:0] hi_col;
    logic [15:0] gap;
    logic [15:0] ofs;
  } interp_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] col;
  } interp_rsp_t;

endpackage

// ===== rtl/gcst_ram.sv =====
// gcst_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gcst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gcst_interp.sv =====
// gcst_interp: four-channel linear interpolation, one multiply step and an
// eight-step restoring divide per channel; depends on gcst_pkg
`timescale 1ns / 1ps

module gcst_interp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gcst_pkg::interp_req_t req_i,
  output gcst_pkg::interp_rsp_t rsp_o
);

  import gcst_pkg::*;

  typedef enum logic [2:0] {
    IS_IDLE = 3'b001,
    IS_MUL  = 3'b010,
    IS_DIV  = 3'b100
  } istate_e;

  istate_e     state_q, state_d;
  logic        done_q, done_d;
  logic [1:0]  ch_q, ch_d;
  logic [2:0]  bit_q, bit_d;
  logic [23:0] num_q, num_d;
  logic [7:0]  quo_q, quo_d;
  logic [31:0] lo_q, lo_d, hi_q, hi_d, res_q, res_d;
  logic [15:0] gap_q, gap_d, ofs_q, ofs_d;

  logic [4:0]  lsb;
  logic [7:0]  a_ch, b_ch;
  logic [15:0] rest;
  logic [23:0] num_w, trial;
  logic [7:0]  quo_nx;
  logic        hit;

  // channel 0 is red, in the high byte
  assign lsb   = {~ch_q, 3'b000};
  assign a_ch  = lo_q[lsb +: 8];
  assign b_ch  = hi_q[lsb +: 8];
  assign rest  = gap_q - ofs_q;
  assign num_w = 24'(a_ch) * 24'(rest) + 24'(b_ch) * 24'(ofs_q);
  assign trial = 24'(gap_q) << bit_q;
  assign hit   = (num_q >= trial);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    ch_d    = ch_q;
    bit_d   = bit_q;
    num_d   = num_q;
    quo_d   = quo_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    res_d   = res_q;
    gap_d   = gap_q;
    ofs_d   = ofs_q;
    quo_nx  = quo_q;
    unique case (state_q)
      IS_IDLE: begin
        if (req_i.start) begin
          lo_d    = req_i.lo_col;
          hi_d    = req_i.hi_col;
          gap_d   = req_i.gap;
          ofs_d   = req_i.ofs;
          ch_d    = 2'd0;
          state_d = IS_MUL;
        end
      end
      IS_MUL: begin
        num_d   = num_w;
        quo_d   = 8'd0;
        bit_d   = 3'd7;
        state_d = IS_DIV;
      end
      IS_DIV: begin
        if (hit) begin
          num_d          = num_q - trial;
          quo_nx[bit_q]  = 1'b1;
        end
        quo_d = quo_nx;
        if (bit_q == 3'd0) begin
          res_d[lsb +: 8] = quo_nx;
          if (ch_q == 2'd3) begin
            done_d  = 1'b1;
            state_d = IS_IDLE;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = IS_MUL;
          end
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      default: state_d = IS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q  <= ch_d;
    bit_q <= bit_d;
    num_q <= num_d;
    quo_q <= quo_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    res_q <= res_d;
    gap_q <= gap_d;
    ofs_q <= ofs_d;
  end

  assign rsp_o = '{done: done_q, col: res_q};

endmodule

// ===== rtl/color_gradient_stop_table_top.sv =====
// color_gradient_stop_table_top: sorted gradient stop table with sequencer
// depends on gcst_pkg, gcst_ram and gcst_interp
`timescale 1ns / 1ps

// usage
// - s_axis carries one request per beat: op in tuser, position and new color in
//   tdata; m_axis returns exactly one result per request, in order
// - the apb port holds top_color (0x0) and bottom_color (0x4); they reach the
//   table only on a restart request
// - one request is worked on at a time; the stop table lives in a ram with
//   registered read, so every table step is a read state, then a use state
// - an add searches for the slot, then overwrites a stop at the same position
//   or shifts the stops above it up; a mirrored add runs the presence check,
//   then one or two adds unless refused; a mirror is refused after its first
//   pass or else runs all three
// - a lookup below the first stop or above the last needs no interpolation;
//   between stops i-1 and i it waits on the interpolation unit (multiply and
//   8-step divide per channel, then its done flag); a restart writes the two end stops
// - a finished result sits in the output register; the next request is taken
//   while it waits, and a stalled receiver holds the sequencer only when a
//   second result is ready
// - after reset the table is loaded with the two end stops, in ST_INIT0 and
//   ST_INIT1, during which no request is taken

module color_gradient_stop_table_top #(
  parameter int unsigned MAX_STOPS = gcst_pkg::MaxStopsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // position[15:0] red green blue alpha
  input  logic [2:0]  s_axis_tuser,  // op
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_red out_green out_blue out_alpha
                                     // refused stop_count[4:0] zero pad
  // apb config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import gcst_pkg::*;

  localparam int unsigned AW = $clog2(MAX_STOPS);
  localparam int unsigned NW = $clog2(MAX_STOPS + 1);

  localparam logic RegTopColor    = 1'b0;
  localparam logic RegBottomColor = 1'b1;

  typedef enum logic [22:0] {
    ST_INIT0    = 23'd1 << 0,
    ST_INIT1    = 23'd1 << 1,
    ST_IDLE     = 23'd1 << 2,
    ST_HAS_RD   = 23'd1 << 3,
    ST_HAS_EV   = 23'd1 << 4,
    ST_PUT_RD   = 23'd1 << 5,
    ST_PUT_EV   = 23'd1 << 6,
    ST_PUT_INS  = 23'd1 << 7,
    ST_SH_RD    = 23'd1 << 8,
    ST_SH_WR    = 23'd1 << 9,
    ST_PUT_NEXT = 23'd1 << 10,
    ST_LK_RD    = 23'd1 << 11,
    ST_LK_EV    = 23'd1 << 12,
    ST_LK_WAIT  = 23'd1 << 13,
    ST_M1_RD    = 23'd1 << 14,
    ST_M1_EV    = 23'd1 << 15,
    ST_M2_RD    = 23'd1 << 16,
    ST_M2_WR    = 23'd1 << 17,
    ST_M3_RD    = 23'd1 << 18,
    ST_M3_WR    = 23'd1 << 19,
    ST_RS0      = 23'd1 << 20,
    ST_RS1      = 23'd1 << 21,
    ST_FIN      = 23'd1 << 22
  } state_e;

  state_e      state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;       // stops held
  logic [NW-1:0] j_q, j_d;           // scan / destination index
  logic [NW-1:0] k_q, k_d;           // shift index, scratch fill or remaining
  logic [15:0] put_pos_q, put_pos_d;
  logic [31:0] put_col_q, put_col_d;
  logic [15:0] mir_pos_q, mir_pos_d;
  logic        second_q, second_d;
  logic        has_cp_q, has_cp_d, has_mp_q, has_mp_d;
  logic [15:0] last_h_q, last_h_d;
  logic [15:0] lk_pos_q, lk_pos_d;
  stop_t       prev_q, prev_d;
  logic [31:0] color_q, color_d;
  logic        refused_q, refused_d;
  logic [31:0] top_color_q, bottom_color_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_color_q, out_color_d;
  logic        out_refused_q, out_refused_d;
  logic [4:0]  out_count_q, out_count_d;

  // table and scratch ram ports
  logic          tb_we, sc_we;
  logic [AW-1:0] tb_waddr, tb_raddr, sc_waddr, sc_raddr;
  stop_t         tb_wdata, tb_rdata, sc_wdata, sc_rdata;

  interp_req_t ireq;
  interp_rsp_t irsp;

  // request decode
  logic        in_acc;
  op_e         in_op;
  logic [15:0] in_pos, in_cp;
  logic [31:0] in_col;

  logic [NW-1:0] km1;
  logic [NW:0]   need_tot, mir_cnt;
  logic [1:0]    need;
  logic          mid;
  logic [15:0]   half;
  logic          cfg_wr;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_op  = op_e'(s_axis_tuser);
  assign in_pos = s_axis_tdata[15:0];
  assign in_col = {s_axis_tdata[23:16], s_axis_tdata[31:24],
                   s_axis_tdata[39:32], s_axis_tdata[47:40]};
  // positions above 1.0 saturate for adds
  assign in_cp  = (in_pos > OnePos) ? OnePos : in_pos;

  assign km1  = k_q - 1'b1;
  assign need = {1'b0, ~has_cp_q} + {1'b0, (mir_pos_q != put_pos_q) && !has_mp_q};
  assign need_tot = {1'b0, cnt_q} + (NW + 1)'(need);
  // a stop at 0.5 appears in both halves of a mirrored table only once
  assign mid     = (last_h_q == HalfPos);
  assign mir_cnt = {k_q, 1'b0} - (NW + 1)'(mid);
  assign half    = {1'b0, tb_rdata.pos[15:1]};

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    j_d           = j_q;
    k_d           = k_q;
    put_pos_d     = put_pos_q;
    put_col_d     = put_col_q;
    mir_pos_d     = mir_pos_q;
    second_d      = second_q;
    has_cp_d      = has_cp_q;
    has_mp_d      = has_mp_q;
    last_h_d      = last_h_q;
    lk_pos_d      = lk_pos_q;
    prev_d        = prev_q;
    color_d       = color_q;
    refused_d     = refused_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_color_d   = out_color_q;
    out_refused_d = out_refused_q;
    out_count_d   = out_count_q;

    tb_we    = 1'b0;
    tb_waddr = j_q[AW-1:0];
    tb_wdata = '{pos: put_pos_q, col: put_col_q};
    tb_raddr = j_q[AW-1:0];
    sc_we    = 1'b0;
    sc_waddr = k_q[AW-1:0];
    sc_wdata = '{pos: half, col: tb_rdata.col};
    sc_raddr = j_q[AW-1:0];
    ireq     = '{start: 1'b0, lo_col: prev_q.col, hi_col: tb_rdata.col,
                 gap: tb_rdata.pos - prev_q.pos, ofs: lk_pos_q - prev_q.pos};

    unique case (state_q)
      ST_INIT0: begin
        tb_we    = 1'b1;
        tb_waddr = AW'(0);
        tb_wdata = '{pos: 16'd0, col: BottomColorRst};
        state_d  = ST_INIT1;
      end
      ST_INIT1: begin
        tb_we    = 1'b1;
        tb_waddr = AW'(1);
        tb_wdata = '{pos: OnePos, col: TopColorRst};
        state_d  = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          color_d   = 32'd0;
          refused_d = 1'b0;
          put_pos_d = in_cp;
          put_col_d = in_col;
          mir_pos_d = OnePos - in_cp;
          lk_pos_d  = in_pos;
          j_d       = '0;
          k_d       = '0;
          has_cp_d  = 1'b0;
          has_mp_d  = 1'b0;
          second_d  = 1'b0;
          unique case (in_op)
            OP_ADD:        state_d = ST_PUT_RD;
            OP_ADD_MIRROR: state_d = ST_HAS_RD;
            OP_MIRROR:     state_d = ST_M1_RD;
            OP_LOOKUP:     state_d = ST_LK_RD;
            OP_RESTART:    state_d = ST_RS0;
            default:       state_d = ST_FIN;
          endcase
        end
      end
      // presence check of both mirrored positions
      ST_HAS_RD: begin
        if (j_q == cnt_q) begin
          if (need_tot > (NW + 1)'(MAX_STOPS)) begin
            refused_d = 1'b1;
            state_d   = ST_FIN;
          end else begin
            j_d      = '0;
            second_d = 1'b1;
            state_d  = ST_PUT_RD;
          end
        end else begin
          state_d = ST_HAS_EV;
        end
      end
      ST_HAS_EV: begin
        if (tb_rdata.pos == put_pos_q) has_cp_d = 1'b1;
        if (tb_rdata.pos == mir_pos_q) has_mp_d = 1'b1;
        j_d     = j_q + 1'b1;
        state_d = ST_HAS_RD;
      end
      // search for the insert slot
      ST_PUT_RD: begin
        state_d = (j_q == cnt_q) ? ST_PUT_INS : ST_PUT_EV;
      end
      ST_PUT_EV: begin
        if (tb_rdata.pos < put_pos_q) begin
          j_d     = j_q + 1'b1;
          state_d = ST_PUT_RD;
        end else if (tb_rdata.pos == put_pos_q) begin
          tb_we   = 1'b1;
          state_d = ST_PUT_NEXT;
        end else begin
          state_d = ST_PUT_INS;
        end
      end
      ST_PUT_INS: begin
        if (cnt_q == NW'(MAX_STOPS)) begin
          refused_d = 1'b1;
          state_d   = ST_FIN;
        end else begin
          k_d     = cnt_q;
          state_d = ST_SH_RD;
        end
      end
      // shift entries above the slot up by one, top first
      ST_SH_RD: begin
        if (k_q == j_q) begin
          tb_we   = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_PUT_NEXT;
        end else begin
          tb_raddr = km1[AW-1:0];
          state_d  = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        tb_we    = 1'b1;
        tb_waddr = k_q[AW-1:0];
        tb_wdata = tb_rdata;
        k_d      = km1;
        state_d  = ST_SH_RD;
      end
      ST_PUT_NEXT: begin
        if (second_q) begin
          second_d  = 1'b0;
          put_pos_d = mir_pos_q;
          j_d       = '0;
          state_d   = ST_PUT_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      // lookup: first stop at or above the position
      ST_LK_RD: begin
        if (j_q == cnt_q) begin
          color_d = prev_q.col;
          state_d = ST_FIN;
        end else begin
          state_d = ST_LK_EV;
        end
      end
      ST_LK_EV: begin
        if (lk_pos_q <= tb_rdata.pos) begin
          if (j_q == '0) begin
            color_d = tb_rdata.col;
            state_d = ST_FIN;
          end else begin
            ireq.start = 1'b1;
            state_d    = ST_LK_WAIT;
          end
        end else begin
          prev_d  = tb_rdata;
          j_d     = j_q + 1'b1;
          state_d = ST_LK_RD;
        end
      end
      ST_LK_WAIT: begin
        if (irsp.done) begin
          color_d = irsp.col;
          state_d = ST_FIN;
        end
      end
      // mirror pass one: distinct halved positions into scratch, last color wins
      ST_M1_RD: begin
        if (j_q == cnt_q) begin
          if (mir_cnt > (NW + 1)'(MAX_STOPS)) begin
            refused_d = 1'b1;
            state_d   = ST_FIN;
          end else begin
            j_d     = '0;
            state_d = ST_M2_RD;
          end
        end else begin
          state_d = ST_M1_EV;
        end
      end
      ST_M1_EV: begin
        sc_we = 1'b1;
        if (k_q != '0 && half == last_h_q) begin
          sc_waddr = km1[AW-1:0];
        end else begin
          k_d = k_q + 1'b1;
        end
        last_h_d = half;
        j_d      = j_q + 1'b1;
        state_d  = ST_M1_RD;
      end
      // pass two: lower half ascending
      ST_M2_RD: begin
        if (j_q == k_q) begin
          k_d     = k_q - NW'(mid);
          state_d = ST_M3_RD;
        end else begin
          state_d = ST_M2_WR;
        end
      end
      ST_M2_WR: begin
        tb_we    = 1'b1;
        tb_wdata = sc_rdata;
        j_d      = j_q + 1'b1;
        state_d  = ST_M2_RD;
      end
      // pass three: upper half from the scratch top down
      ST_M3_RD: begin
        if (k_q == '0) begin
          cnt_d   = j_q;
          state_d = ST_FIN;
        end else begin
          sc_raddr = km1[AW-1:0];
          state_d  = ST_M3_WR;
        end
      end
      ST_M3_WR: begin
        tb_we    = 1'b1;
        tb_wdata = '{pos: OnePos - sc_rdata.pos, col: sc_rdata.col};
        j_d      = j_q + 1'b1;
        k_d      = km1;
        state_d  = ST_M3_RD;
      end
      ST_RS0: begin
        tb_we    = 1'b1;
        tb_waddr = AW'(0);
        tb_wdata = '{pos: 16'd0, col: bottom_color_q};
        state_d  = ST_RS1;
      end
      ST_RS1: begin
        tb_we    = 1'b1;
        tb_waddr = AW'(1);
        tb_wdata = '{pos: OnePos, col: top_color_q};
        cnt_d    = NW'(2);
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d   = 1'b1;
          out_color_d   = color_q;
          out_refused_d = refused_q;
          out_count_d   = 5'(cnt_q);
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT0;
      cnt_q       <= NW'(2);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q           <= j_d;
    k_q           <= k_d;
    put_pos_q     <= put_pos_d;
    put_col_q     <= put_col_d;
    mir_pos_q     <= mir_pos_d;
    second_q      <= second_d;
    has_cp_q      <= has_cp_d;
    has_mp_q      <= has_mp_d;
    last_h_q      <= last_h_d;
    lk_pos_q      <= lk_pos_d;
    prev_q        <= prev_d;
    color_q       <= color_d;
    refused_q     <= refused_d;
    out_color_q   <= out_color_d;
    out_refused_q <= out_refused_d;
    out_count_q   <= out_count_d;
  end

  // config registers
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_color_q    <= TopColorRst;
      bottom_color_q <= BottomColorRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegBottomColor) begin
        bottom_color_q <= pwdata;
      end else begin
        top_color_q <= pwdata;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegTopColor) ? top_color_q : bottom_color_q;

  gcst_ram #(
    .Width(StopW),
    .Depth(MAX_STOPS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tb_we),
    .waddr_i(tb_waddr),
    .wdata_i(tb_wdata),
    .raddr_i(tb_raddr),
    .rdata_o(tb_rdata)
  );

  gcst_ram #(
    .Width(StopW),
    .Depth(MAX_STOPS)
  ) u_scratch (
    .clk_i  (clk_i),
    .we_i   (sc_we),
    .waddr_i(sc_waddr),
    .wdata_i(sc_wdata),
    .raddr_i(sc_raddr),
    .rdata_o(sc_rdata)
  );

  gcst_interp u_interp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ireq),
    .rsp_o (irsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_count_q, out_refused_q,
                          out_color_q[7:0], out_color_q[15:8],
                          out_color_q[23:16], out_color_q[31:24]};

endmodule
